FILE: rtl/vmu_pkg.sv
`timescale 1ns / 1ps
package vmu_pkg;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_SCALE  = 4'd3,
      OP_DIV    = 4'd4,
      OP_NEG    = 4'd5,
      OP_DOT    = 4'd6,
      OP_CROSS  = 4'd7,
      OP_LENGTH = 4'd8,
      OP_UNIT   = 4'd9,
      OP_EQUAL  = 4'd10
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DIVZ = 2'd1,
      ST_SAT  = 2'd2
   } status_type;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 32;
   localparam logic [30:0] TOL_RESET = 31'd66;

   // one input beat
   typedef struct packed {
      logic [3:0]       op;
      logic [2:0][31:0] a;
      logic [2:0][31:0] b;
      logic [31:0]      s;
   } in_type;

   // payload of the long back half (sqrt and divide)
   typedef struct packed {
      logic [3:0]       op;
      logic [2:0][31:0] rv;
      logic [31:0]      sc;
      logic             eq;
      logic             sat;
      logic             dz;
      logic             sneg;
      logic [2:0][31:0] a;
      logic [31:0]      dvs;
      logic [63:0]      sqn;
      logic [63:0]      sqr;
      logic [2:0][63:0] rem;
      logic [2:0][31:0] quo;
      logic [2:0]       neg;
      logic [2:0]       big;
   } pipe_type;

   // clamp to 32-bit signed range: {saturated, value}
   function automatic logic [32:0] clamp66(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sd2147483647) begin
         r = {1'b1, 32'h7FFF_FFFF};
      end else if (v < -66'sd2147483648) begin
         r = {1'b1, 32'h8000_0000};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

FILE: rtl/vector3_math_unit.sv
`timescale 1ns / 1ps
// channel   | valid / stall         | payload
// ----------+-----------------------+--------------------------------------------
// request   | req_valid / req_stall | req_opcode, req_ax..req_bz, req_scale_value
// response  | rsp_valid / rsp_stall | rsp_rx, rsp_ry, rsp_rz, rsp_scalar_result,
//           |                       | rsp_equal_flag, rsp_status
// config    | csr_wr_en             | csr_wr_data (equal tolerance)
//
// One beat enters per cycle while the pipeline advances; every opcode passes through the same stages.
// Depth is set by the 32-stage square root followed by the 32-stage divider.
// Synchronous reset empties the pipeline and sets the tolerance to 66.
// A one-entry skid buffer at the input takes a beat while the output is stalled;
// req_stall is a flop, the whole pipeline holds while rsp_valid && rsp_stall.
module vector3_math_unit import vmu_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [3:0]  req_opcode,
   input  logic [31:0] req_ax,
   input  logic [31:0] req_ay,
   input  logic [31:0] req_az,
   input  logic [31:0] req_bx,
   input  logic [31:0] req_by_comp,
   input  logic [31:0] req_bz,
   input  logic [31:0] req_scale_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_rx,
   output logic [31:0] rsp_ry,
   output logic [31:0] rsp_rz,
   output logic [31:0] rsp_scalar_result,
   output logic        rsp_equal_flag,
   output logic [1:0]  rsp_status,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data
);

   localparam int NPIPE = 1 + SQRT_STEPS + 1 + DIV_STEPS;
   localparam int NV    = 3 + NPIPE + 1;
   localparam int PREP  = SQRT_STEPS + 1;

   logic [30:0]    tol_ff;
   logic           advance;
   logic           in_acc;
   logic           skid_vld_ff, skid_vld_in;
   in_type         skid_ff, req_beat, s0_beat;
   logic           s0_vld;
   logic [NV-1:0]  vld_ff;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   // input skid buffer
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = skid_vld_ff;
   assign in_acc    = req_valid && !req_stall;

   always_comb begin
      req_beat.op = req_opcode;
      req_beat.a  = {req_az, req_ay, req_ax};
      req_beat.b  = {req_bz, req_by_comp, req_bx};
      req_beat.s  = req_scale_value;
   end

   always_comb begin
      skid_vld_in = skid_vld_ff;
      if (advance) begin
         skid_vld_in = 1'b0;
      end else if (in_acc) begin
         skid_vld_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_vld_ff <= 1'b0;
      end else begin
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!advance && in_acc) begin
         skid_ff <= req_beat;
      end
   end

   assign s0_vld  = skid_vld_ff || in_acc;
   assign s0_beat = skid_vld_ff ? skid_ff : req_beat;

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NV-2:0], s0_vld};
      end
   end

   // stage A: capture
   in_type in_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         in_ff <= s0_beat;
      end
   end

   // stage B: operand select, add/sub/neg/difference
   logic [5:0][31:0]   mx_in, my_in, mx_ff, my_ff;
   logic signed [32:0] as_in [3];
   logic signed [32:0] as_b_ff [3];
   in_type             b_ff;

   always_comb begin
      mx_in = '0;
      my_in = '0;
      unique case (in_ff.op)
         OP_MUL, OP_DOT: begin
            mx_in[2:0] = in_ff.a;
            my_in[2:0] = in_ff.b;
         end
         OP_SCALE: begin
            mx_in[2:0] = in_ff.a;
            my_in[2:0] = {in_ff.s, in_ff.s, in_ff.s};
         end
         OP_CROSS: begin
            mx_in = {in_ff.a[1], in_ff.a[0], in_ff.a[0], in_ff.a[2], in_ff.a[2], in_ff.a[1]};
            my_in = {in_ff.b[0], in_ff.b[1], in_ff.b[2], in_ff.b[0], in_ff.b[1], in_ff.b[2]};
         end
         OP_LENGTH, OP_UNIT: begin
            mx_in[2:0] = in_ff.a;
            my_in[2:0] = in_ff.a;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         unique case (in_ff.op)
            OP_ADD:           as_in[i] = 33'($signed(in_ff.a[i])) + 33'($signed(in_ff.b[i]));
            OP_SUB, OP_EQUAL: as_in[i] = 33'($signed(in_ff.a[i])) - 33'($signed(in_ff.b[i]));
            OP_NEG:           as_in[i] = -33'($signed(in_ff.a[i]));
            default:          as_in[i] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mx_ff   <= mx_in;
         my_ff   <= my_in;
         as_b_ff <= as_in;
         b_ff    <= in_ff;
      end
   end

   // stage C: multiply
   logic signed [63:0] prod_in [6];
   logic signed [63:0] prod_ff [6];
   logic signed [32:0] as_c_ff [3];
   in_type             c_ff;

   always_comb begin
      for (int j = 0; j < 6; j++) begin
         prod_in[j] = $signed(mx_ff[j]) * $signed(my_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         as_c_ff <= as_b_ff;
         c_ff    <= b_ff;
      end
   end

   // stage D: shift, sum, clamp; set up sqrt and divide
   pipe_type           pipe_ff [NPIPE];
   pipe_type           d_in;
   logic signed [63:0] shp [3];
   logic signed [65:0] dot_sum, dot_sh;
   logic signed [65:0] crs [3];
   logic [32:0]        cl;
   logic [32:0]        absd;

   always_comb begin
      d_in      = '0;
      d_in.op   = c_ff.op;
      d_in.a    = c_ff.a;
      d_in.sneg = c_ff.s[31];
      dot_sum   = 66'(prod_ff[0]) + 66'(prod_ff[1]) + 66'(prod_ff[2]);
      dot_sh    = dot_sum >>> FRAC_BITS;
      for (int i = 0; i < 3; i++) begin
         shp[i] = prod_ff[i] >>> FRAC_BITS;
         crs[i] = (66'(prod_ff[2*i]) - 66'(prod_ff[2*i+1])) >>> FRAC_BITS;
      end
      cl   = '0;
      absd = '0;
      unique case (c_ff.op)
         OP_ADD, OP_SUB, OP_NEG: begin
            for (int i = 0; i < 3; i++) begin
               cl         = clamp66(66'(as_c_ff[i]));
               d_in.rv[i] = cl[31:0];
               d_in.sat   = d_in.sat | cl[32];
            end
         end
         OP_MUL, OP_SCALE: begin
            for (int i = 0; i < 3; i++) begin
               cl         = clamp66(66'(shp[i]));
               d_in.rv[i] = cl[31:0];
               d_in.sat   = d_in.sat | cl[32];
            end
         end
         OP_CROSS: begin
            for (int i = 0; i < 3; i++) begin
               cl         = clamp66(crs[i]);
               d_in.rv[i] = cl[31:0];
               d_in.sat   = d_in.sat | cl[32];
            end
         end
         OP_DOT: begin
            cl       = clamp66(dot_sh);
            d_in.sc  = cl[31:0];
            d_in.sat = cl[32];
         end
         OP_LENGTH, OP_UNIT: begin
            d_in.sqn = 64'(prod_ff[0]) + 64'(prod_ff[1]) + 64'(prod_ff[2]);
         end
         OP_DIV: begin
            d_in.dz  = (c_ff.s == '0);
            d_in.dvs = c_ff.s[31] ? (~c_ff.s + 32'd1) : c_ff.s;
         end
         OP_EQUAL: begin
            d_in.eq = 1'b1;
            for (int i = 0; i < 3; i++) begin
               absd = as_c_ff[i][32] ? 33'(-as_c_ff[i]) : 33'(as_c_ff[i]);
               if (!(absd < {2'b00, tol_ff})) begin
                  d_in.eq = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pipe_ff[0] <= d_in;
      end
   end

   // sqrt stages, divide setup, divide stages
   for (genvar k = 1; k < NPIPE; k++) begin : g_stage
      pipe_type nxt;
      if (k <= SQRT_STEPS) begin : g_sqrt
         localparam logic [63:0] BIT = 64'd1 << (64 - 2*k);
         always_comb begin
            nxt = pipe_ff[k-1];
            if (pipe_ff[k-1].sqn >= pipe_ff[k-1].sqr + BIT) begin
               nxt.sqn = pipe_ff[k-1].sqn - (pipe_ff[k-1].sqr + BIT);
               nxt.sqr = (pipe_ff[k-1].sqr >> 1) + BIT;
            end else begin
               nxt.sqr = pipe_ff[k-1].sqr >> 1;
            end
         end
      end else if (k == PREP) begin : g_prep
         logic [31:0] len;
         logic [31:0] mag;
         logic [63:0] num;
         always_comb begin
            nxt = pipe_ff[k-1];
            len = pipe_ff[k-1].sqr[31:0];
            mag = '0;
            num = '0;
            if (pipe_ff[k-1].op == OP_LENGTH) begin
               nxt.sc  = len[31] ? 32'h7FFF_FFFF : len;
               nxt.sat = len[31];
            end
            if (pipe_ff[k-1].op == OP_UNIT) begin
               nxt.dz   = (len == '0);
               nxt.dvs  = len;
               nxt.sneg = 1'b0;
            end
            for (int i = 0; i < 3; i++) begin
               mag = pipe_ff[k-1].a[i][31] ? (~pipe_ff[k-1].a[i] + 32'd1)
                                           : pipe_ff[k-1].a[i];
               num = 64'(mag) << FRAC_BITS;
               nxt.rem[i] = num;
               nxt.quo[i] = '0;
               nxt.neg[i] = pipe_ff[k-1].a[i][31] ^ nxt.sneg;
               nxt.big[i] = (num[63:32] >= nxt.dvs);
            end
         end
      end else begin : g_div
         localparam int SH = DIV_STEPS - 1 - (k - PREP - 1);
         logic [63:0] dsh;
         always_comb begin
            nxt = pipe_ff[k-1];
            dsh = 64'(pipe_ff[k-1].dvs) << SH;
            for (int i = 0; i < 3; i++) begin
               if (pipe_ff[k-1].rem[i] >= dsh) begin
                  nxt.rem[i]     = pipe_ff[k-1].rem[i] - dsh;
                  nxt.quo[i][SH] = 1'b1;
               end
            end
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            pipe_ff[k] <= nxt;
         end
      end
   end

   // final stage: sign and clamp quotients, form status
   pipe_type    fin;
   logic [2:0][31:0] q_val;
   logic        q_sat;
   logic [31:0] rx_ff, ry_ff, rz_ff, sc_ff;
   logic        eq_ff;
   logic [1:0]  st_ff;
   logic [3:0]  op_ff;
   logic [1:0]  st_in;

   assign fin = pipe_ff[NPIPE-1];

   always_comb begin
      q_val = fin.rv;
      q_sat = fin.sat;
      if ((fin.op == OP_DIV || fin.op == OP_UNIT) && !fin.dz) begin
         for (int i = 0; i < 3; i++) begin
            if (fin.big[i]) begin
               q_val[i] = fin.neg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
               q_sat    = 1'b1;
            end else if (fin.neg[i]) begin
               if (fin.quo[i] > 32'h8000_0000) begin
                  q_val[i] = 32'h8000_0000;
                  q_sat    = 1'b1;
               end else begin
                  q_val[i] = ~fin.quo[i] + 32'd1;
               end
            end else if (fin.quo[i][31]) begin
               q_val[i] = 32'h7FFF_FFFF;
               q_sat    = 1'b1;
            end else begin
               q_val[i] = fin.quo[i];
            end
         end
      end
      priority if (fin.dz) begin
         st_in = ST_DIVZ;
      end else if (q_sat) begin
         st_in = ST_SAT;
      end else begin
         st_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rx_ff <= fin.dz ? '0 : q_val[0];
         ry_ff <= fin.dz ? '0 : q_val[1];
         rz_ff <= fin.dz ? '0 : q_val[2];
         sc_ff <= fin.sc;
         eq_ff <= fin.eq;
         st_ff <= st_in;
         op_ff <= fin.op;
      end
   end

   assign rsp_valid         = vld_ff[NV-1];
   assign rsp_rx            = rx_ff;
   assign rsp_ry            = ry_ff;
   assign rsp_rz            = rz_ff;
   assign rsp_scalar_result = sc_ff;
   assign rsp_equal_flag    = eq_ff;
   assign rsp_status        = st_ff;

   // checks
   a_reset_empty : assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(!advance))
      else $error("skid buffer filled while pipeline advanced");

   a_divz_op : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_DIVZ |-> op_ff == OP_DIV || op_ff == OP_UNIT)
      else $error("divide-by-zero status on a non-divide opcode");

   a_equal_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_equal_flag |-> rsp_status == ST_OK && rsp_rx == '0 && op_ff == OP_EQUAL)
      else $error("equal flag with other result fields set");

endmodule
